@@ hdl/odc_pkg.sv @@
// Shared types and constants for the depth clustering block.
`default_nettype none

package odc_pkg;

  // Per-cluster statistics widths
  localparam int N_W = 24;
  localparam int S_W = 40;
  localparam int Q_W = 56;

  // Shared datapath widths
  localparam int ACC_W = 82;
  localparam int MC_W  = 80;
  localparam int MP_W  = 40;
  localparam int D_W   = 48;
  localparam int R_W   = 40;

  // Score format and divider shape
  localparam int SCORE_W = 24;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = 26;
  localparam int DCNT_W  = 5;
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(QUO_W);
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Initial square-root probe bit: highest power of four in the operand
  localparam logic [MC_W-1:0] SQ_ONE_INIT = {2'b01, {(MC_W-2){1'b0}}};

  // Configuration registers
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ZSCORE_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_ERR_LIMIT = 1'b1;
  localparam logic [CFG_W-1:0] ZLIM_RESET = 16'd512;
  localparam logic [CFG_W-1:0] RLIM_RESET = 16'd6554;

  // Output field widths
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XX_MUL,
    ST_FETCH,
    ST_NX_INIT,
    ST_NX_MUL,
    ST_D_SUB,
    ST_D_ABS,
    ST_NQ_MUL,
    ST_SS_MUL,
    ST_SQ_INIT,
    ST_SQ_STEP,
    ST_ZDIV_INIT,
    ST_ZDIV,
    ST_RDIV_INIT,
    ST_RDIV,
    ST_SCORE,
    ST_DECIDE,
    ST_UFETCH,
    ST_UWRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ hdl/online_depth_clustering.sv @@
// Online leader clustering of depth samples on one shared add/subtract unit.
//
// Use: a sample beat (sample, trial_only) enters on sample_valid while
// sample_stall is low; one result beat leaves on result_valid per sample,
// taken while result_stall is low. The user writes limits on cfg_write with
// cfg_index/cfg_data while the block is idle; the block does not enforce it.
// Each cluster in use takes a fetch, three shift-add multiplies and, unless
// skipped, a 40-step square root and two 26-step divisions, all on the
// one 82-bit adder. sample_stall stays high from acceptance until the
// result is loaded into the output register; the next sample is then
// taken while that result still waits. A stalled receiver holds the
// block in its final step with the result pending.
// Reset clears all clusters by zeroing the count in use, clears result_valid
// and restores the limits to their defaults; no clearing pass is needed.
`default_nettype none

module online_depth_clustering
  import odc_pkg::*;
#(
  parameter int MAX_CLUSTERS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   trial_only,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic                        matched,
  output logic [OUT_IDX_W-1:0]        cluster_index,
  output logic                        created,
  output logic                        dropped,
  output logic [SCORE_W-1:0]          fit_score,
  output logic [OUT_CNT_W-1:0]        clusters_in_use
);

  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int XX_W  = 2 * SAMPLE_BITS;
  localparam int CL_SHIFT = Q_W - 2 * SAMPLE_BITS;
  localparam logic [N_W-1:0] COUNT_LIMIT =
    (CL_SHIFT < N_W) ? N_W'((64'd1 << CL_SHIFT) - 64'd1) : {N_W{1'b1}};

  state_t state, state_next;

  logic [SAMPLE_BITS-1:0] x, x_next;
  logic                   trial, trial_next;
  logic [XX_W-1:0]        xx, xx_next;
  logic [ACC_W-1:0]       acc, acc_next;
  logic [MC_W-1:0]        mcand, mcand_next;
  logic [MP_W-1:0]        mplier, mplier_next;
  logic [MC_W-1:0]        one, one_next;
  logic [DCNT_W-1:0]      cnt, cnt_next;
  logic [D_W-1:0]         d, d_next;
  logic [R_W-1:0]         root, root_next;
  logic [SCORE_W-1:0]     zp, zp_next, rp, rp_next;
  logic                   zok, zok_next, rok, rok_next;
  logic                   found, found_next;
  logic [IDX_W-1:0]       best, best_next;
  logic [SCORE_W-1:0]     best_score, best_score_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [CNT_W-1:0]       used, used_next;
  logic [CFG_W-1:0]       zlim, rlim;

  // Pending result
  logic                   p_matched, p_matched_next;
  logic [IDX_W-1:0]       p_index, p_index_next;
  logic                   p_created, p_created_next;
  logic                   p_dropped, p_dropped_next;
  logic [SCORE_W-1:0]     p_fit, p_fit_next;
  logic                   load_out;

  // Cluster table
  logic [N_W-1:0] mem_n [MAX_CLUSTERS];
  logic [S_W-1:0] mem_s [MAX_CLUSTERS];
  logic [Q_W-1:0] mem_q [MAX_CLUSTERS];
  logic [N_W-1:0] rd_n;
  logic [S_W-1:0] rd_s;
  logic [Q_W-1:0] rd_q;
  logic           wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [N_W-1:0] wr_n;
  logic [S_W-1:0] wr_s;
  logic [Q_W-1:0] wr_q;

  // Shared adder
  logic [ACC_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

  logic                 mul_done;
  logic [QUO_W-1:0]     quo;
  logic [SCORE_W-1:0]   quo_sat;
  logic [SCORE_W:0]     score_sum;
  logic [SCORE_W-1:0]   score;

  assign mul_done  = (mplier == '0);
  assign quo       = mplier[QUO_W-1:0];
  assign quo_sat   = (quo[QUO_W-1:SCORE_W] != '0) ? SCORE_MAX : quo[SCORE_W-1:0];
  assign score_sum = {1'b0, zp} + {1'b0, rp};
  assign score     = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];

  assign sample_stall = (state != ST_IDLE);

  // Sequencer and datapath next values
  always_comb begin
    state_next      = state;
    x_next          = x;
    trial_next      = trial;
    xx_next         = xx;
    acc_next        = acc;
    mcand_next      = mcand;
    mplier_next     = mplier;
    one_next        = one;
    cnt_next        = cnt;
    d_next          = d;
    root_next       = root;
    zp_next         = zp;
    rp_next         = rp;
    zok_next        = zok;
    rok_next        = rok;
    found_next      = found;
    best_next       = best;
    best_score_next = best_score;
    idx_next        = idx;
    used_next       = used;
    p_matched_next  = p_matched;
    p_index_next    = p_index;
    p_created_next  = p_created;
    p_dropped_next  = p_dropped;
    p_fit_next      = p_fit;
    load_out        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_n            = '0;
    wr_s            = '0;
    wr_q            = '0;
    add_a           = acc;
    add_b           = mplier[0] ? ACC_W'(mcand) : '0;
    add_sub         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          x_next          = sample;
          trial_next      = trial_only;
          acc_next        = '0;
          mcand_next      = MC_W'(sample);
          mplier_next     = MP_W'(sample);
          found_next      = 1'b0;
          best_next       = '0;
          best_score_next = '0;
          idx_next        = '0;
          state_next      = ST_XX_MUL;
        end
      end

      // x*x for the update and create paths
      ST_XX_MUL: begin
        if (mul_done) begin
          xx_next    = acc[XX_W-1:0];
          state_next = (used == '0) ? ST_DECIDE : ST_FETCH;
        end else begin
          acc_next    = add_sum;
          mcand_next  = mcand << 1;
          mplier_next = mplier >> 1;
        end
      end

      ST_FETCH: state_next = ST_NX_INIT;

      ST_NX_INIT: begin
        acc_next    = '0;
        mcand_next  = MC_W'(x);
        mplier_next = MP_W'(rd_n);
        state_next  = ST_NX_MUL;
      end

      ST_NX_MUL: begin
        if (mul_done) begin
          state_next = ST_D_SUB;
        end else begin
          acc_next    = add_sum;
          mcand_next  = mcand << 1;
          mplier_next = mplier >> 1;
        end
      end

      // D = |n*x - S|
      ST_D_SUB: begin
        add_b      = ACC_W'(rd_s);
        add_sub    = 1'b1;
        acc_next   = add_sum;
        state_next = ST_D_ABS;
      end

      ST_D_ABS: begin
        add_a       = '0;
        add_b       = acc;
        add_sub     = 1'b1;
        d_next      = acc[ACC_W-1] ? add_sum[D_W-1:0] : acc[D_W-1:0];
        acc_next    = '0;
        mcand_next  = MC_W'(rd_q);
        mplier_next = MP_W'(rd_n);
        state_next  = ST_NQ_MUL;
      end

      // V = n*Q - S*S, accumulated in place
      ST_NQ_MUL: begin
        if (mul_done) begin
          mcand_next  = MC_W'(rd_s);
          mplier_next = MP_W'(rd_s);
          state_next  = ST_SS_MUL;
        end else begin
          acc_next    = add_sum;
          mcand_next  = mcand << 1;
          mplier_next = mplier >> 1;
        end
      end

      ST_SS_MUL: begin
        add_sub = 1'b1;
        if (mul_done) begin
          state_next = ST_SQ_INIT;
        end else begin
          acc_next    = add_sum;
          mcand_next  = mcand << 1;
          mplier_next = mplier >> 1;
        end
      end

      // Negative variance counts as zero
      ST_SQ_INIT: begin
        if (acc[ACC_W-1]) begin
          root_next  = '0;
          state_next = ST_ZDIV_INIT;
        end else begin
          mcand_next = '0;
          one_next   = SQ_ONE_INIT;
          state_next = ST_SQ_STEP;
        end
      end

      // Digit-by-digit square root: acc is the remainder, mcand the root
      ST_SQ_STEP: begin
        add_b   = ACC_W'(mcand | one);
        add_sub = 1'b1;
        if (one == '0) begin
          root_next  = mcand[R_W-1:0];
          state_next = ST_ZDIV_INIT;
        end else begin
          if (!add_sum[ACC_W-1]) begin
            acc_next   = add_sum;
            mcand_next = (mcand >> 1) | one;
          end else begin
            mcand_next = mcand >> 1;
          end
          one_next = one >> 2;
        end
      end

      ST_ZDIV_INIT: begin
        if (root == '0) begin
          zp_next    = (d == '0) ? '0 : SCORE_MAX;
          zok_next   = (d == '0);
          state_next = ST_RDIV_INIT;
        end else begin
          acc_next    = ACC_W'(d) << FRAC_W;
          mcand_next  = MC_W'(root) << (QUO_W - 1);
          mplier_next = '0;
          cnt_next    = '0;
          state_next  = ST_ZDIV;
        end
      end

      ST_RDIV_INIT: begin
        if (rd_s == '0) begin
          rp_next    = (d == '0) ? '0 : SCORE_MAX;
          rok_next   = 1'b0;
          state_next = ST_SCORE;
        end else begin
          acc_next    = ACC_W'(d) << FRAC_W;
          mcand_next  = MC_W'(rd_s) << (QUO_W - 1);
          mplier_next = '0;
          cnt_next    = '0;
          state_next  = ST_RDIV;
        end
      end

      // Restoring division, quotient collects in mplier
      ST_ZDIV, ST_RDIV: begin
        add_b   = ACC_W'(mcand);
        add_sub = 1'b1;
        if (cnt == DIV_STEPS) begin
          if (state == ST_ZDIV) begin
            zp_next    = quo_sat;
            zok_next   = (quo < (QUO_W'(zlim) << 8));
            state_next = ST_RDIV_INIT;
          end else begin
            rp_next    = quo_sat;
            rok_next   = (quo < QUO_W'(rlim));
            state_next = ST_SCORE;
          end
        end else begin
          if (!add_sum[ACC_W-1]) begin
            acc_next    = add_sum;
            mplier_next = {mplier[MP_W-2:0], 1'b1};
          end else begin
            mplier_next = {mplier[MP_W-2:0], 1'b0};
          end
          mcand_next = mcand >> 1;
          cnt_next   = cnt + 1'b1;
        end
      end

      // Keep the lowest-scoring fit, lowest index on a tie
      ST_SCORE: begin
        if ((zok || rok) && (!found || (score < best_score))) begin
          found_next      = 1'b1;
          best_next       = idx;
          best_score_next = score;
        end
        if ((CNT_W'(idx) + CNT_W'(1)) == used) begin
          state_next = ST_DECIDE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_FETCH;
        end
      end

      ST_DECIDE: begin
        p_matched_next = 1'b0;
        p_created_next = 1'b0;
        p_dropped_next = 1'b0;
        p_index_next   = '0;
        p_fit_next     = '0;
        state_next     = ST_DONE;
        if (found) begin
          p_matched_next = 1'b1;
          p_index_next   = best;
          p_fit_next     = best_score;
          if (!trial) begin
            idx_next   = best;
            state_next = ST_UFETCH;
          end
        end else if (used < CNT_W'(MAX_CLUSTERS)) begin
          p_created_next = 1'b1;
          p_index_next   = IDX_W'(used);
          if (!trial) begin
            wr_en     = 1'b1;
            wr_addr   = IDX_W'(used);
            wr_n      = N_W'(1);
            wr_s      = S_W'(x);
            wr_q      = Q_W'(xx);
            used_next = used + 1'b1;
          end
        end else begin
          p_dropped_next = 1'b1;
        end
      end

      ST_UFETCH: state_next = ST_UWRITE;

      // A cluster at the count limit still matches but is left as is
      ST_UWRITE: begin
        if (rd_n < COUNT_LIMIT) begin
          wr_en = 1'b1;
          wr_n  = rd_n + 1'b1;
          wr_s  = rd_s + S_W'(x);
          wr_q  = rd_q + Q_W'(xx);
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      found <= found_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x          <= x_next;
    trial      <= trial_next;
    xx         <= xx_next;
    acc        <= acc_next;
    mcand      <= mcand_next;
    mplier     <= mplier_next;
    one        <= one_next;
    cnt        <= cnt_next;
    d          <= d_next;
    root       <= root_next;
    zp         <= zp_next;
    rp         <= rp_next;
    zok        <= zok_next;
    rok        <= rok_next;
    best       <= best_next;
    best_score <= best_score_next;
    idx        <= idx_next;
    p_matched  <= p_matched_next;
    p_index    <= p_index_next;
    p_created  <= p_created_next;
    p_dropped  <= p_dropped_next;
    p_fit      <= p_fit_next;
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zlim <= ZLIM_RESET;
      rlim <= RLIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZSCORE_LIMIT:  zlim <= cfg_data;
        REG_REL_ERR_LIMIT: rlim <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cluster table: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_n[wr_addr] <= wr_n;
      mem_s[wr_addr] <= wr_s;
      mem_q[wr_addr] <= wr_q;
    end
    rd_n <= mem_n[idx];
    rd_s <= mem_s[idx];
    rd_q <= mem_q[idx];
  end

  // Output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      matched         <= p_matched;
      cluster_index   <= OUT_IDX_W'(p_index);
      created         <= p_created;
      dropped         <= p_dropped;
      fit_score       <= p_fit;
      clusters_in_use <= OUT_CNT_W'(used);
    end
  end

  // Exactly one outcome per result
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot({matched, created, dropped}))
    else $error("result carries no single outcome");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(MAX_CLUSTERS))
    else $error("cluster count beyond table size");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) <= used))
    else $error("table write beyond clusters in use");

  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && dropped) |-> (fit_score == '0 && cluster_index == '0))
    else $error("dropped result with nonzero fields");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !(result_valid && result_stall))
      |=> (result_valid && state == ST_IDLE))
    else $error("finished result not loaded");

endmodule

`default_nettype wire

@@ bench/online_depth_clustering_test.sv @@
// Self-checking testbench for the online depth clustering block.
`default_nettype none

module online_depth_clustering_test
  import odc_pkg::*;
();

  localparam int NCL = 16;
  localparam int HOLD_LEN = 20000;
  localparam logic [23:0] COUNT_CAP = 24'hFFFFFF;

  typedef struct packed {
    logic        matched;
    logic [3:0]  cluster_index;
    logic        created;
    logic        dropped;
    logic [23:0] fit_score;
    logic [4:0]  clusters_in_use;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ZSCORE_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [15:0] sample = '0;
  logic trial_only = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic matched, created, dropped;
  logic [3:0] cluster_index;
  logic [23:0] fit_score;
  logic [4:0] clusters_in_use;

  online_depth_clustering dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample(sample), .trial_only(trial_only), .result_valid(result_valid),
    .result_stall(result_stall), .matched(matched), .cluster_index(cluster_index),
    .created(created), .dropped(dropped), .fit_score(fit_score),
    .clusters_in_use(clusters_in_use)
  );

  always #10 clk = ~clk;

  // Predictor state
  logic [15:0] zlim, rlim;
  logic [23:0] cnt [NCL];
  logic [39:0] ssum [NCL];
  logic [55:0] qsum [NCL];
  logic [4:0]  used;

  verdict_t pending [$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;

  function automatic logic [40:0] isqrt(logic [127:0] v);
    logic [40:0] r;
    logic [40:0] c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (41'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Score one cluster against a sample; returns fit flag
  function automatic bit score_cluster(int k, logic [15:0] x, output logic [23:0] sc);
    logic [127:0] n, s, q, nx, d, nq, ss, r, zp, rp, t;
    bit zok, rok;
    n = 128'(cnt[k]); s = 128'(ssum[k]); q = 128'(qsum[k]);
    nx = n * 128'(x);
    d = nx >= s ? nx - s : s - nx;
    nq = n * q; ss = s * s;
    r = ss <= nq ? 128'(isqrt(nq - ss)) : '0;
    if (r == 0) begin
      zok = (d == 0);
      zp = d == 0 ? '0 : 128'hFFFFFF;
    end else begin
      zok = (d << 8) < 128'(zlim) * r;
      zp = (d << 16) / r;
      if (zp > 128'hFFFFFF) zp = 128'hFFFFFF;
    end
    if (s == 0) begin
      rok = 1'b0;
      rp = d == 0 ? '0 : 128'hFFFFFF;
    end else begin
      rok = (d << 16) < 128'(rlim) * s;
      rp = (d << 16) / s;
      if (rp > 128'hFFFFFF) rp = 128'hFFFFFF;
    end
    t = zp + rp;
    sc = t > 128'hFFFFFF ? 24'hFFFFFF : t[23:0];
    return zok || rok;
  endfunction

  function automatic verdict_t cluster_sample(logic [15:0] x, logic trial);
    verdict_t v;
    logic [23:0] sc, best_sc;
    int best;
    bit found;
    v = '0; best = 0; best_sc = '0; found = 0;
    for (int i = 0; i < used; i++)
      if (score_cluster(i, x, sc) && (!found || sc < best_sc)) begin
        found = 1; best = i; best_sc = sc;
      end
    if (found) begin
      v.matched = 1; v.cluster_index = best[3:0]; v.fit_score = best_sc;
      if (!trial && cnt[best] < COUNT_CAP) begin
        cnt[best] += 1; ssum[best] += 40'(x); qsum[best] += 56'(x) * 56'(x);
      end
    end else if (used < NCL) begin
      v.created = 1; v.cluster_index = used[3:0];
      if (!trial) begin
        cnt[used] = 24'd1; ssum[used] = 40'(x); qsum[used] = 56'(x) * 56'(x); used++;
      end
    end else
      v.dropped = 1;
    v.clusters_in_use = used;
    return v;
  endfunction

  task automatic report(string what, logic [35:0] got, logic [35:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Result side: check each beat
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0)
        report("unexpected beat", 36'(1), 36'(0));
      else begin
        verdict_t e;
        e = pending.pop_front();
        if (matched !== e.matched) report("matched", 36'(matched), 36'(e.matched));
        if (cluster_index !== e.cluster_index)
          report("cluster_index", 36'(cluster_index), 36'(e.cluster_index));
        if (created !== e.created) report("created", 36'(created), 36'(e.created));
        if (dropped !== e.dropped) report("dropped", 36'(dropped), 36'(e.dropped));
        if (fit_score !== e.fit_score)
          report("fit_score", 36'(fit_score), 36'(e.fit_score));
        if (clusters_in_use !== e.clusters_in_use)
          report("clusters_in_use", 36'(clusters_in_use), 36'(e.clusters_in_use));
      end
    end
  end

  // Receiver stall; the long hold-off is counted here
  always @(posedge clk) begin
    if (hold_req && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      result_stall <= 1'b1;
    end else
      result_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_ZSCORE_LIMIT) zlim = val; else rlim = val;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (3400) @(posedge clk);
  endtask

  // Offer one beat, wait until taken, queue the prediction; check it when known
  task automatic send(logic [15:0] x, logic trial, bit has_want, verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1; sample <= x; trial_only <= trial;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    v = cluster_sample(x, trial);
    if (has_want && v !== want) report("table row", v, want);
    pending = {pending, v};
  endtask

  // Directed rows
  typedef struct {
    logic [15:0] x;
    logic trial;
    bit has_want;
    verdict_t want;
  } row_t;

  row_t rows [] = '{
    '{16'd1000, 1'b1, 1, '{0, 4'd0, 1, 0, 24'd0, 5'd0}},  // trial on empty table
    '{16'd1000, 1'b0, 1, '{0, 4'd0, 1, 0, 24'd0, 5'd1}},
    '{16'd1000, 1'b0, 1, '{1, 4'd0, 0, 0, 24'd0, 5'd1}},  // zero deviation, exact
    '{16'd1001, 1'b0, 0, '0},                             // zero deviation, off
    '{16'd0,    1'b0, 0, '0},
    '{16'd0,    1'b0, 0, '0},                             // zero mean cluster
    '{16'd65535, 1'b0, 0, '0},
    '{16'd65535, 1'b1, 0, '0},
    '{16'd65534, 1'b0, 0, '0},
    '{16'd32768, 1'b0, 0, '0},
    '{16'd1,    1'b0, 0, '0},
    '{16'd20000, 1'b0, 0, '0},
    '{16'd5000, 1'b0, 0, '0},
    '{16'd40000, 1'b0, 0, '0},
    '{16'd12000, 1'b0, 0, '0},
    '{16'd50000, 1'b0, 0, '0},
    '{16'd8000, 1'b0, 0, '0},
    '{16'd3000, 1'b0, 0, '0},
    '{16'd60000, 1'b0, 0, '0},
    '{16'd25000, 1'b0, 0, '0},
    '{16'd15000, 1'b0, 0, '0},
    '{16'd45000, 1'b0, 0, '0},
    '{16'd2,    1'b1, 0, '0},
    '{16'd23456, 1'b0, 0, '0},
    '{16'd10000, 1'b0, 0, '0},
    '{16'd55000, 1'b0, 0, '0},                            // last free slot
    '{16'd2,    1'b0, 1, '{0, 4'd0, 0, 1, 24'd0, 5'd16}}  // table full: dropped
  };

  // Random sample: mostly near existing clusters, some anywhere
  function automatic logic [15:0] pick_sample();
    int k;
    longint m;
    if (used == 0 || $urandom_range(3) == 0) return 16'($urandom);
    k = $urandom_range(used - 1);
    m = ssum[k] / cnt[k];
    m += $signed($urandom_range(2000)) - 1000;
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    return m[15:0];
  endfunction

  task automatic random_phase(int items, int idle, int stall);
    send_idle = idle; recv_stall = stall;
    repeat (items) send(pick_sample(), $urandom_range(7) == 0, 0, '0);
  endtask

  initial begin
    int phase;
    zlim = ZLIM_RESET; rlim = RLIM_RESET; used = '0;
    for (int i = 0; i < NCL; i++) begin
      cnt[i] = '0; ssum[i] = '0; qsum[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under reset limits
    foreach (rows[i]) send(rows[i].x, rows[i].trial, rows[i].has_want, rows[i].want);
    drain();

    // Wipe table knowledge is impossible without reset, so sweep limits on a full table
    for (phase = 0; phase < 8; phase++) begin
      unique case (phase)
        0: begin write_reg(REG_ZSCORE_LIMIT, 16'd0); write_reg(REG_REL_ERR_LIMIT, 16'd0); end
        1: begin write_reg(REG_ZSCORE_LIMIT, 16'hFFFF); write_reg(REG_REL_ERR_LIMIT, 16'hFFFF); end
        2: begin write_reg(REG_ZSCORE_LIMIT, 16'd256); write_reg(REG_REL_ERR_LIMIT, 16'd0); end
        3: begin write_reg(REG_ZSCORE_LIMIT, 16'd0); write_reg(REG_REL_ERR_LIMIT, 16'd3277); end
        default: begin
          write_reg(REG_ZSCORE_LIMIT, 16'($urandom));
          write_reg(REG_REL_ERR_LIMIT, 16'($urandom));
        end
      endcase
      unique case (phase % 4)
        0: random_phase(250, 0, 0);
        1: random_phase(250, 49, 0);
        2: random_phase(250, 0, 49);
        default: random_phase(250, 37, 37);
      endcase
      if (phase == 2) begin
        // long receiver hold-off while samples keep coming
        hold_req = 1'b1;
        random_phase(6, 0, 0);
      end
      drain();  // sender waits for every result
    end
    drain();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #800000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ online_depth_clustering.f @@
hdl/odc_pkg.sv
hdl/online_depth_clustering.sv
bench/online_depth_clustering_test.sv
